/* hw/rtl/tas_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tas_pkg: shared types and constants
// Types, table selectors, alarm states and constants of the supervisor.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int LIMIT_ENTRIES  = 4;
    localparam int ACTION_ENTRIES = 4;
    localparam int TAB_DEPTH      = 16;   // four tables of four entries
    localparam int TAB_AW         = 4;

    localparam logic [15:0] SKIP_VALUE = 16'hFFFF;
    localparam logic [7:0]  IDX_ALL    = 8'hFF;
    localparam logic [7:0]  NEVER      = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RPTMAX = 2'd1,
        OP_RPTMIN = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TAB_MAX  = 2'd0,
        TAB_MIN  = 2'd1,
        TAB_WARN = 2'd2,
        TAB_ERR  = 2'd3
    } tab_sel_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_WMAX = 3'd1,
        ST_EMAX = 3'd2,
        ST_WMIN = 3'd3,
        ST_EMIN = 3'd4
    } alarm_t;

    localparam logic CFG_WARN = 1'b0;
    localparam logic CFG_ERR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_TICK,
        S_EMIT,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic        used;
        logic [7:0]  var_id;
        logic [7:0]  var_idx;
        logic [15:0] a;
        logic [15:0] b;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  table_sel;
        logic [1:0]  entry_idx;
        logic        entry_used;
        logic [7:0]  var_id;
        logic [7:0]  var_idx;
        logic        var_indexed;
        logic [15:0] level_a;
        logic [15:0] level_b;
        logic [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic        action_valid;
        logic [7:0]  act_var_id;
        logic [7:0]  act_var_idx;
        logic [15:0] act_value;
        logic [2:0]  alarm_state;
        logic [1:0]  active_entry;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/tas_table_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tas_table_ram: entry store of all four tables
// One write port and one registered read port; a per-entry valid bit makes
// unwritten entries read as unused with zero fields.
// ----------------------------------------------------------------------------
module tas_table_ram
    import tas_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [TAB_AW-1:0] waddr,
    input  wire entry_t            wdata,
    input  wire logic [TAB_AW-1:0] raddr,
    output entry_t                 rdata
);

    entry_t                 mem [TAB_DEPTH];
    logic [TAB_DEPTH-1:0]   vld_reg;
    entry_t                 rd_reg;
    logic                   rv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rv_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rv_reg ? rd_reg : '0;

endmodule
`default_nettype wire

/* hw/rtl/threshold_alarm_supervisor_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_alarm_supervisor_top: safety-threshold supervisor
// Checks reported samples against limit tables and emits alarm actions.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid/in_stall) carries a table write, a
// max- or min-checked report, or a one-second tick. Each input transaction
// yields one to eight output transactions (out_valid/out_stall); the final
// one has last set. Actions come out in table order; an item that causes
// none gives one status transaction with action_valid low.
// All tables live in one 16-entry memory with a registered read, so the
// block reads entries one per cycle while no held action stalls a scan. A
// write reads no entry; a report reads the limit table in order up to the
// first match and, when it raises an alarm, scans one action table; a tick
// reads nothing in hold-off or in OK, reads the watched limit entry when
// evaluated, and scans one or two action tables when it recovers. One item
// is worked on at a time; in_stall is high until its last output
// transaction is taken, so the next input transaction is taken in the cycle
// after that at the earliest.
// The receiver may stall as long as it likes; the output holds, and a scan
// that meets a held action waits.
// Reset clears all tables to unused, the alarm state to OK and both
// confirm times to 5.
// ----------------------------------------------------------------------------
module threshold_alarm_supervisor_top
    import tas_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic [7:0] cfg_data
);

    fsm_t        st_reg, st_next;
    in_item_t    it_reg, it_next;
    logic [7:0]  wconf_reg, wconf_next, econf_reg, econf_next;
    alarm_t      mode_reg, mode_next;
    logic [1:0]  mon_reg, mon_next;
    logic [7:0]  good_reg, good_next, hold_reg, hold_next;
    logic [2:0]  cnt_reg, cnt_next;     // entry counter, one past read
    logic        rdv_reg, rdv_next;     // read data valid this cycle
    logic [1:0]  hit_reg, hit_next;
    logic        found_reg, found_next;
    logic [1:0]  etab_reg, etab_next;   // action table being emitted
    logic        eraise_reg, eraise_next;
    logic        emore_reg, emore_next; // second emit pass follows
    logic [3:0]  nres_reg, nres_next;
    out_item_t   ob_reg, ob_next;
    logic        ov_reg, ov_next;
    logic        pend_reg, pend_next;   // held action waiting to go out
    out_item_t   pd_reg, pd_next;

    logic              we;
    logic [TAB_AW-1:0] waddr, raddr;
    entry_t            wdata, rdata;

    tas_table_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; wconf_reg <= 8'd5; econf_reg <= 8'd5;
            mode_reg <= ST_OK; mon_reg <= '0; good_reg <= '0; hold_reg <= '0;
            cnt_reg <= '0; rdv_reg <= 1'b0; hit_reg <= '0; found_reg <= 1'b0;
            etab_reg <= '0; eraise_reg <= 1'b0; emore_reg <= 1'b0;
            nres_reg <= '0; ov_reg <= 1'b0; pend_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; wconf_reg <= wconf_next; econf_reg <= econf_next;
            mode_reg <= mode_next; mon_reg <= mon_next; good_reg <= good_next;
            hold_reg <= hold_next; cnt_reg <= cnt_next; rdv_reg <= rdv_next;
            hit_reg <= hit_next; found_reg <= found_next; etab_reg <= etab_next;
            eraise_reg <= eraise_next; emore_reg <= emore_next;
            nres_reg <= nres_next; ov_reg <= ov_next; pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        ob_reg <= ob_next;
        pd_reg <= pd_next;
    end

    assign in_stall  = (st_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = ob_reg;

    logic        is_max_rpt, in_err, idx_ok, good, t_max, t_warn, to_warn;
    logic        out_free;
    logic [15:0] lvl, av;
    logic [2:0]  ent_cnt;
    logic [1:0]  rd_ent;
    logic [7:0]  good_inc, wait_t;

    always_comb
    begin
        st_next = st_reg; it_next = it_reg;
        wconf_next = wconf_reg; econf_next = econf_reg;
        mode_next = mode_reg; mon_next = mon_reg; good_next = good_reg;
        hold_next = hold_reg; cnt_next = cnt_reg; rdv_next = 1'b0;
        hit_next = hit_reg; found_next = found_reg; etab_next = etab_reg;
        eraise_next = eraise_reg; emore_next = emore_reg; nres_next = nres_reg;
        ob_next = ob_reg; ov_next = ov_reg; pend_next = pend_reg; pd_next = pd_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        lvl = '0; av = '0; good = 1'b0; to_warn = 1'b0;
        rd_ent = cnt_reg[1:0] - 2'd1;
        ent_cnt = 3'(ACTION_ENTRIES);
        is_max_rpt = (it_reg.op == OP_RPTMAX);
        in_err = (mode_reg == ST_EMAX) || (mode_reg == ST_EMIN);
        t_max = (mode_reg == ST_WMAX) || (mode_reg == ST_EMAX);
        t_warn = (mode_reg == ST_WMAX) || (mode_reg == ST_WMIN);
        wait_t = t_warn ? wconf_reg : econf_reg;
        good_inc = (good_reg == 8'hFF) ? good_reg : good_reg + 8'd1;
        idx_ok = 1'b0;
        out_free = !ov_reg || !out_stall;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_WARN) wconf_next = cfg_data;
            else                        econf_next = cfg_data;
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    it_next = in_data;
                    nres_next = '0;
                    pend_next = 1'b0;
                    cnt_next = '0;
                    found_next = 1'b0;
                    unique case (op_t'(in_data.op))
                        OP_WRITE:
                        begin
                            we = 1'b1;
                            waddr = {in_data.table_sel, in_data.entry_idx};
                            wdata = '{used: in_data.entry_used, var_id: in_data.var_id,
                                      var_idx: in_data.var_idx, a: in_data.level_a,
                                      b: in_data.level_b};
                            st_next = S_OUT;
                        end
                        OP_TICK:   st_next = S_TICK;
                        default:   st_next = S_LOOK;
                    endcase
                end
            end
            S_LOOK:
            begin
                // Read entry cnt; check the one read last cycle.
                raddr = {(is_max_rpt ? TAB_MAX : TAB_MIN), cnt_reg[1:0]};
                if (rdv_reg && !found_reg && rdata.used && rdata.var_id == it_reg.var_id
                    && (!it_reg.var_indexed || rdata.var_idx == IDX_ALL
                        || rdata.var_idx == it_reg.var_idx))
                begin
                    found_next = 1'b1;
                    hit_next = rd_ent;
                    st_next = S_OUT;
                    if (is_max_rpt)
                    begin
                        if (rdata.b != 16'd0 && it_reg.sample >= rdata.b && !in_err)
                            idx_ok = 1'b1;
                        else if (rdata.a != 16'd0 && it_reg.sample >= rdata.a
                                 && mode_reg == ST_OK)
                            to_warn = 1'b1;
                    end
                    else
                    begin
                        if (rdata.b != 16'd0 && it_reg.sample <= rdata.b && !in_err)
                            idx_ok = 1'b1;
                        else if (rdata.a != 16'd0 && it_reg.sample <= rdata.a
                                 && mode_reg == ST_OK)
                            to_warn = 1'b1;
                    end
                    if (idx_ok || to_warn)
                    begin
                        mode_next = idx_ok ? (is_max_rpt ? ST_EMAX : ST_EMIN)
                                           : (is_max_rpt ? ST_WMAX : ST_WMIN);
                        hold_next = wconf_reg;
                        mon_next = rd_ent;
                        etab_next = idx_ok ? TAB_ERR : TAB_WARN;
                        eraise_next = 1'b1;
                        emore_next = 1'b0;
                        cnt_next = '0;
                        st_next = S_EMIT;
                    end
                end
                else if (cnt_reg == 3'(LIMIT_ENTRIES))
                begin
                    st_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                    rdv_next = 1'b1;
                end
            end
            S_TICK:
            begin
                raddr = {(t_max ? TAB_MAX : TAB_MIN), mon_reg};
                if (mode_reg == ST_OK)
                begin
                    st_next = S_OUT;
                end
                else if (hold_reg > 8'd1)
                begin
                    hold_next = hold_reg - 8'd1;
                    st_next = S_OUT;
                end
                else if (!rdv_reg)
                begin
                    rdv_next = 1'b1;
                end
                else
                begin
                    hold_next = '0;
                    lvl = t_warn ? rdata.a : rdata.b;
                    good = t_max ? (it_reg.sample < lvl) : (it_reg.sample >= lvl);
                    st_next = S_OUT;
                    if (wait_t == NEVER)
                    begin
                        st_next = S_OUT;
                    end
                    else if (!good)
                    begin
                        good_next = '0;
                    end
                    else if (good_inc >= wait_t)
                    begin
                        good_next = '0;
                        mon_next = '0;
                        to_warn = !t_warn && (t_max ? (it_reg.sample >= rdata.a)
                                                   : (it_reg.sample <= rdata.a));
                        mode_next = to_warn ? (t_max ? ST_WMAX : ST_WMIN) : ST_OK;
                        etab_next = to_warn ? TAB_ERR : TAB_WARN;
                        eraise_next = 1'b0;
                        emore_next = to_warn;
                        cnt_next = '0;
                        st_next = S_EMIT;
                    end
                    else
                    begin
                        good_next = good_inc;
                    end
                end
            end
            S_EMIT:
            begin
                // Scan the action table; each usable entry becomes an output, up to eight per item.
                // The newest one is held back so the final output can carry last.
                raddr = {etab_reg, cnt_reg[1:0]};
                if (rdv_reg)
                begin
                    av = eraise_reg ? rdata.a : rdata.b;
                    if (rdata.used && av != SKIP_VALUE && nres_reg < 4'd8)
                    begin
                        if (pend_reg)
                        begin
                            if (out_free)
                            begin
                                ob_next = pd_reg;
                                ov_next = 1'b1;
                            end
                            else
                            begin
                                // Wait: hold the read and retry it.
                                rdv_next = 1'b0;
                                cnt_next = cnt_reg - 3'd1;
                                av = '0;
                            end
                        end
                        if (!pend_reg || out_free)
                        begin
                            pend_next = 1'b1;
                            nres_next = nres_reg + 4'd1;
                            pd_next = '{action_valid: 1'b1, act_var_id: rdata.var_id,
                                        act_var_idx: rdata.var_idx, act_value: av,
                                        alarm_state: mode_reg, active_entry: mon_reg,
                                        last: 1'b0};
                        end
                    end
                end
                if (cnt_next == ent_cnt && (rdv_next || !rdv_reg || cnt_reg == ent_cnt)
                    && cnt_reg == ent_cnt)
                begin
                    if (emore_reg)
                    begin
                        etab_next = TAB_WARN;
                        eraise_next = 1'b1;
                        emore_next = 1'b0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        st_next = S_OUT;
                    end
                end
                else if (cnt_reg != ent_cnt && cnt_next == cnt_reg)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    rdv_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ob_next = pend_reg ? pd_reg : '0;
                    ob_next.alarm_state = mode_reg;
                    ob_next.active_entry = mon_reg;
                    ob_next.last = 1'b1;
                    pend_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.alarm_state == ST_OK) |-> !in_err || !out_data.last)
        else $error("status mismatch");

endmodule
`default_nettype wire

/* bench/threshold_alarm_supervisor_top_tb.sv */
// ----------------------------------------------------------------------------
// threshold_alarm_supervisor_top_tb: self-checking bench for the supervisor
// A queue-fed driver sends table writes, reports and ticks. A monitor runs a
// cycle-free model of the alarm logic on each accepted transaction and checks
// every output transaction against it. Confirm times change between phases.
// ----------------------------------------------------------------------------
module threshold_alarm_supervisor_top_tb;
    import tas_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_WARN;
    logic [7:0] cfg_data = '0;

    threshold_alarm_supervisor_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Model state of the supervisor.
    entry_t lim_max [LIMIT_ENTRIES];
    entry_t lim_min [LIMIT_ENTRIES];
    entry_t act_warn [ACTION_ENTRIES];
    entry_t act_err [ACTION_ENTRIES];
    alarm_t alarm_mode;
    logic [1:0] watch_entry;
    logic [7:0] good_run;
    logic [7:0] holdoff;
    logic [7:0] warn_secs;
    logic [7:0] err_secs;

    out_item_t pending_actions[$];
    out_item_t alarm_expect[$];
    in_item_t  item_queue[$];

    int sent_cnt = 0;
    int acc_cnt = 0;
    int errors = 0;
    int cycles = 0;
    int idle_phase = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    task automatic emit_acts(input bit from_err, input bit raise);
        entry_t e;
        out_item_t o;
        for (int i = 0; i < ACTION_ENTRIES; i++) begin
            e = from_err ? act_err[i] : act_warn[i];
            o = '0;
            o.action_valid = 1'b1;
            o.act_var_id   = e.var_id;
            o.act_var_idx  = e.var_idx;
            o.act_value    = raise ? e.a : e.b;
            if (e.used && o.act_value != SKIP_VALUE && pending_actions.size() < 8)
                pending_actions.push_back(o);
        end
    endtask

    task automatic raise_alarm(input alarm_t mode, input int hit, input bit is_err);
        alarm_mode  = mode;
        holdoff     = warn_secs;
        watch_entry = hit[1:0];
        emit_acts(is_err, 1'b1);
    endtask

    task automatic run_report(input in_item_t it);
        bit is_max;
        bit in_err;
        int hit;
        entry_t e;
        is_max = (it.op == OP_RPTMAX);
        in_err = (alarm_mode == ST_EMAX || alarm_mode == ST_EMIN);
        hit = -1;
        for (int i = 0; i < LIMIT_ENTRIES; i++) begin
            e = is_max ? lim_max[i] : lim_min[i];
            if (hit < 0 && e.used && e.var_id == it.var_id &&
                (!it.var_indexed || e.var_idx == IDX_ALL || e.var_idx == it.var_idx))
                hit = i;
        end
        if (hit < 0)
            return;
        e = is_max ? lim_max[hit] : lim_min[hit];
        if (is_max) begin
            if (e.b > 0 && it.sample >= e.b && !in_err)
                raise_alarm(ST_EMAX, hit, 1'b1);
            else if (e.a > 0 && it.sample >= e.a && alarm_mode == ST_OK)
                raise_alarm(ST_WMAX, hit, 1'b0);
        end
        else begin
            if (e.b > 0 && it.sample <= e.b && !in_err)
                raise_alarm(ST_EMIN, hit, 1'b1);
            else if (e.a > 0 && it.sample <= e.a && alarm_mode == ST_OK)
                raise_alarm(ST_WMIN, hit, 1'b0);
        end
    endtask

    task automatic run_tick(input logic [15:0] cur);
        bit is_max;
        bit is_warn;
        bit good;
        bit to_warn;
        entry_t e;
        logic [15:0] level;
        logic [7:0] wait_secs;
        if (alarm_mode == ST_OK)
            return;
        if (holdoff > 1) begin
            holdoff--;
            return;
        end
        holdoff = '0;
        is_max  = (alarm_mode == ST_WMAX || alarm_mode == ST_EMAX);
        is_warn = (alarm_mode == ST_WMAX || alarm_mode == ST_WMIN);
        // The watched entry is used as it stands now, even if rewritten.
        e = is_max ? lim_max[watch_entry] : lim_min[watch_entry];
        level = is_warn ? e.a : e.b;
        wait_secs = is_warn ? warn_secs : err_secs;
        if (wait_secs == NEVER)
            return;
        good = is_max ? (cur < level) : (cur >= level);
        if (!good) begin
            good_run = '0;
            return;
        end
        if (good_run != 8'hFF)
            good_run++;
        if (good_run < wait_secs)
            return;
        good_run = '0;
        to_warn = !is_warn && (is_max ? (cur >= e.a) : (cur <= e.a));
        if (to_warn) begin
            alarm_mode = is_max ? ST_WMAX : ST_WMIN;
            emit_acts(1'b1, 1'b0);
            emit_acts(1'b0, 1'b1);
        end
        else begin
            alarm_mode = ST_OK;
            emit_acts(1'b0, 1'b0);
        end
        holdoff = '0;
        watch_entry = '0;
    endtask

    task automatic predict_alarm(input in_item_t it);
        entry_t e;
        out_item_t o;
        pending_actions.delete();
        case (it.op)
            OP_WRITE: begin
                e = '{used: it.entry_used, var_id: it.var_id, var_idx: it.var_idx,
                      a: it.level_a, b: it.level_b};
                case (it.table_sel)
                    TAB_MAX:  lim_max[it.entry_idx] = e;
                    TAB_MIN:  lim_min[it.entry_idx] = e;
                    TAB_WARN: act_warn[it.entry_idx] = e;
                    default:  act_err[it.entry_idx] = e;
                endcase
            end
            OP_TICK: run_tick(it.sample);
            default: run_report(it);
        endcase
        if (pending_actions.size() == 0)
            pending_actions.push_back('0);
        foreach (pending_actions[k]) begin
            o = pending_actions[k];
            o.alarm_state  = alarm_mode;
            o.active_entry = watch_entry;
            o.last         = (k == pending_actions.size() - 1);
            alarm_expect.push_back(o);
        end
    endtask

    // Monitor: predicts on every accepted input and checks every output.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && !in_stall) begin
            predict_alarm(in_data);
            acc_cnt <= acc_cnt + 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (alarm_expect.size() == 0) begin
                if (errors < 10)
                    $display("unexpected output transaction %p", out_data);
                errors <= errors + 1;
            end
            else begin
                if (out_data.action_valid != alarm_expect[0].action_valid ||
                    out_data.act_var_id   != alarm_expect[0].act_var_id   ||
                    out_data.act_var_idx  != alarm_expect[0].act_var_idx  ||
                    out_data.act_value    != alarm_expect[0].act_value    ||
                    out_data.alarm_state  != alarm_expect[0].alarm_state  ||
                    out_data.active_entry != alarm_expect[0].active_entry ||
                    out_data.last         != alarm_expect[0].last) begin
                    if (errors < 10)
                        $display("mismatch: expected %p, got %p", alarm_expect[0], out_data);
                    errors <= errors + 1;
                end
                void'(alarm_expect.pop_front());
            end
        end
        if (cycles > 2000000) begin
            $display("threshold_alarm_supervisor_top_tb: done, errors");
            $finish;
        end
    end

    // Driver: a transaction on the bus stays until it is accepted.
    always @(negedge clk) begin
        if (!(in_valid && sent_cnt != acc_cnt)) begin
            if (rst_n && item_queue.size() > 0 &&
                $urandom_range(99) >= (idle_phase == 0 ? 34 : idle_phase == 1 ? 63 : 0)) begin
                in_data  <= item_queue.pop_front();
                in_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus an occasional long hold.
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= $urandom_range(99) < (idle_phase == 0 ? 63 : idle_phase == 1 ? 34 : 0);
    end

    function automatic in_item_t mk(input op_t op, input tab_sel_t sel, input int idx,
                                    input bit used, input int vid, input int vidx,
                                    input bit indexed, input int la, input int lb,
                                    input int smp);
        in_item_t it;
        it.op = op;
        it.table_sel = sel;
        it.entry_idx = idx[1:0];
        it.entry_used = used;
        it.var_id = vid[7:0];
        it.var_idx = vidx[7:0];
        it.var_indexed = indexed;
        it.level_a = la[15:0];
        it.level_b = lb[15:0];
        it.sample = smp[15:0];
        return it;
    endfunction

    function automatic logic [15:0] rnd_level();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(900, 100));
        endcase
    endfunction

    function automatic in_item_t rnd_item();
        in_item_t it;
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        it = in_item_t'(bits[$bits(in_item_t)-1:0]);
        it.var_id  = ($urandom_range(7) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
        it.var_idx = ($urandom_range(3) == 0) ? 8'($urandom()) :
                     ($urandom_range(1) ? IDX_ALL : 8'($urandom_range(2)));
        it.level_a = rnd_level();
        it.level_b = rnd_level();
        it.sample  = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(1000));
        case ($urandom_range(9))
            0, 1:    it.op = OP_WRITE;
            2, 3:    it.op = OP_RPTMAX;
            4, 5:    it.op = OP_RPTMIN;
            default: it.op = OP_TICK;
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        while (item_queue.size() > 0 || sent_cnt != acc_cnt || alarm_expect.size() > 0)
            @(posedge clk);
        // Allow the block to finish any trailing work before going on.
        repeat (30) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WARN)
            warn_secs = val;
        else
            err_secs = val;
    endtask

    initial begin
        for (int i = 0; i < LIMIT_ENTRIES; i++) begin
            lim_max[i] = '0;
            lim_min[i] = '0;
        end
        for (int i = 0; i < ACTION_ENTRIES; i++) begin
            act_warn[i] = '0;
            act_err[i] = '0;
        end
        alarm_mode = ST_OK;
        watch_entry = '0;
        good_run = '0;
        holdoff = '0;
        warn_secs = 8'd5;
        err_secs = 8'd5;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(CFG_WARN, 8'd2);
        write_cfg(CFG_ERR, 8'd1);
        // Directed: tables, warn raise and clear, error raise and step-down, min side.
        item_queue.push_back(mk(OP_WRITE, TAB_MAX, 0, 1, 10, 255, 0, 100, 200, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_MIN, 1, 1, 20, 3, 1, 50, 10, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_MIN, 0, 1, 30, 0, 0, 0, 0, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_WARN, 0, 1, 255, 255, 1, 65535, 7, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_WARN, 3, 1, 1, 2, 0, 11, 12, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_ERR, 1, 1, 0, 0, 0, 21, 65535, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_ERR, 2, 0, 5, 5, 0, 99, 99, 0));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 500));
        item_queue.push_back(mk(OP_RPTMAX, TAB_MAX, 0, 0, 11, 0, 0, 0, 0, 65535));
        item_queue.push_back(mk(OP_RPTMAX, TAB_MAX, 0, 0, 10, 9, 1, 0, 0, 150));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 150));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 50));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 50));
        item_queue.push_back(mk(OP_RPTMAX, TAB_MAX, 0, 0, 10, 0, 0, 0, 0, 65535));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 150));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 150));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
        item_queue.push_back(mk(OP_RPTMIN, TAB_MAX, 0, 0, 20, 4, 1, 0, 0, 0));
        item_queue.push_back(mk(OP_RPTMIN, TAB_MAX, 0, 0, 20, 3, 1, 0, 0, 5));
        item_queue.push_back(mk(OP_RPTMIN, TAB_MAX, 0, 0, 30, 0, 0, 0, 0, 0));
        item_queue.push_back(mk(OP_WRITE, TAB_MIN, 1, 0, 20, 3, 1, 50, 10, 0));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 65535));
        item_queue.push_back(mk(OP_TICK, TAB_MAX, 0, 0, 0, 0, 0, 0, 0, 65535));
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            idle_phase = p;
            case (p)
                0: begin write_cfg(CFG_WARN, 8'd0); write_cfg(CFG_ERR, 8'd255); end
                1: begin write_cfg(CFG_WARN, 8'd255); write_cfg(CFG_ERR, 8'd0); end
                default: begin write_cfg(CFG_WARN, 8'd3); write_cfg(CFG_ERR, 8'd2); end
            endcase
            for (int j = 0; j < 100; j++)
                item_queue.push_back(rnd_item());
            if (p == 0)
                hold_req = hold_req + 1;
            wait_drained();
            for (int j = 0; j < 7; j++)
                item_queue.push_back(rnd_item());
            wait_drained();
        end

        if (errors == 0 && alarm_expect.size() == 0)
            $display("threshold_alarm_supervisor_top_tb: done, clean");
        else
            $display("threshold_alarm_supervisor_top_tb: done, errors");
        $finish;
    end

endmodule

/* threshold_alarm_supervisor_top.f */
hw/rtl/tas_pkg.sv
hw/rtl/tas_table_ram.sv
hw/rtl/threshold_alarm_supervisor_top.sv
bench/threshold_alarm_supervisor_top_tb.sv
